@@ design/cld_pkg.sv @@
// ----------------------------------------------------------------------------
// cld_pkg: shared types and constants of the CPU lockup detector
// Word formats of the item and result channels, kind codes, register indexes
// and register reset values.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CPU_W   = 4;
    localparam int unsigned PTR_W   = 64;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned PHASE_W = 8;
    localparam int unsigned ACT_W   = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_NMI   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CPUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_EVERY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT  = 2'd2;

    localparam logic [ACT_W-1:0]   ACTIVE_CPUS_RST  = 5'd1;
    localparam logic [PHASE_W-1:0] SAMPLE_EVERY_RST = 8'd3;
    localparam logic [COUNT_W-1:0] STUCK_LIMIT_RST  = 8'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CPU_W-1:0]  cpu_index;
        logic [PTR_W-1:0]  rip_value;
        logic [PTR_W-1:0]  rsp_value;
        logic              idle_skip;
    } t_in_word;

    typedef struct packed {
        logic               stuck_flag;
        logic               newly_stuck;
        logic [COUNT_W-1:0] stuck_count_now;
    } t_out_word;

endpackage

@@ design/cpu_lockup_detector.sv @@
// ----------------------------------------------------------------------------
// cpu_lockup_detector: per-CPU hard lockup detector driven by NMI samples
// Keeps a phase, the last rip/rsp pair, a stuck count and a stuck flag per CPU
// slot; NMI words update them, clear and query words reset or read count and flag.
// ----------------------------------------------------------------------------
// Result path: an accepted word is held in the input register, then the table
//   read-modify-write writes the result register.
// Throughput: one word per cycle unless the output stalls.
// Reset: synchronous active low; config registers return to their defaults, the
//   stage valid flags and per-slot valid bits clear, so every table entry reads as zero.
module cpu_lockup_detector #(
    parameter int unsigned CPU_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cld_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cld_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cld_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cld_pkg::*;

    localparam int unsigned IW = $clog2(CPU_SLOTS);

    logic [ACT_W-1:0]   r_active_cpus;
    logic [PHASE_W-1:0] r_sample_every;
    logic [COUNT_W-1:0] r_stuck_limit;

    logic     r_in_valid;
    t_in_word r_in;
    logic      r_out_valid;
    t_out_word r_out;

    logic [CPU_SLOTS-1:0] r_valid;
    logic [PHASE_W-1:0]   r_phase [CPU_SLOTS];
    logic [PTR_W-1:0]     r_ip    [CPU_SLOTS];
    logic [PTR_W-1:0]     r_sp    [CPU_SLOTS];
    logic [COUNT_W-1:0]   r_cnt   [CPU_SLOTS];
    logic                 r_mark  [CPU_SLOTS];

    logic               advance;
    logic [IW-1:0]      idx;
    logic               in_range;
    logic [PHASE_W-1:0] cur_phase;
    logic [PTR_W-1:0]   cur_ip;
    logic [PTR_W-1:0]   cur_sp;
    logic [COUNT_W-1:0] cur_cnt;
    logic               cur_mark;
    logic [PHASE_W-1:0] every;
    logic [PHASE_W:0]   phase_inc;
    logic               cpu_active;
    logic               examine;
    logic               pair_eq;
    logic [COUNT_W-1:0] cnt_inc;
    logic               table_wr;
    logic [PHASE_W-1:0] n_phase;
    logic [PTR_W-1:0]   n_ip;
    logic [PTR_W-1:0]   n_sp;
    logic [COUNT_W-1:0] n_cnt;
    logic               n_mark;
    t_out_word          n_out;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    assign idx      = IW'(r_in.cpu_index);
    assign in_range = 32'(r_in.cpu_index) < CPU_SLOTS;

    assign cur_phase = r_valid[idx] ? r_phase[idx] : '0;
    assign cur_ip    = r_valid[idx] ? r_ip[idx]    : '0;
    assign cur_sp    = r_valid[idx] ? r_sp[idx]    : '0;
    assign cur_cnt   = r_valid[idx] ? r_cnt[idx]   : '0;
    assign cur_mark  = r_valid[idx] ? r_mark[idx]  : 1'b0;

    assign every      = (r_sample_every == '0) ? PHASE_W'(1) : r_sample_every;
    assign phase_inc  = {1'b0, cur_phase} + (PHASE_W + 1)'(1);
    assign cpu_active = {1'b0, r_in.cpu_index} < r_active_cpus;
    assign examine    = !(cpu_active && r_in.idle_skip) && (cur_phase == '0);
    assign pair_eq    = (r_in.rip_value == cur_ip) && (r_in.rsp_value == cur_sp);
    assign cnt_inc    = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_W'(1);

    always_comb begin
        n_phase  = cur_phase;
        n_ip     = cur_ip;
        n_sp     = cur_sp;
        n_cnt    = cur_cnt;
        n_mark   = cur_mark;
        n_out    = '0;
        table_wr = 1'b0;
        if (in_range) begin
            unique case (r_in.kind)
                KIND_NMI: begin
                    table_wr = 1'b1;
                    n_phase  = (phase_inc >= {1'b0, every}) ? '0 : phase_inc[PHASE_W-1:0];
                    if (examine) begin
                        if (pair_eq) begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= r_stuck_limit) begin
                                n_mark            = 1'b1;
                                n_out.newly_stuck = !cur_mark;
                            end
                        end else begin
                            n_cnt  = '0;
                            n_mark = 1'b0;
                        end
                        n_ip = r_in.rip_value;
                        n_sp = r_in.rsp_value;
                    end
                    n_out.stuck_flag      = n_mark;
                    n_out.stuck_count_now = n_cnt;
                end
                KIND_CLEAR: begin
                    table_wr = 1'b1;
                    n_cnt    = '0;
                    n_mark   = 1'b0;
                end
                KIND_QUERY: begin
                    n_out.stuck_flag      = cpu_active && cur_mark;
                    n_out.stuck_count_now = cur_cnt;
                end
                KIND_RSVD: begin
                    n_out = '0;
                end
                default: begin
                    n_out = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cpus  <= ACTIVE_CPUS_RST;
            r_sample_every <= SAMPLE_EVERY_RST;
            r_stuck_limit  <= STUCK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ACTIVE_CPUS:  r_active_cpus  <= i_cfg_data[ACT_W-1:0];
                REG_SAMPLE_EVERY: r_sample_every <= i_cfg_data;
                REG_STUCK_LIMIT:  r_stuck_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && table_wr) begin
                r_valid[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
        if (advance && table_wr) begin
            r_phase[idx] <= n_phase;
            r_ip[idx]    <= n_ip;
            r_sp[idx]    <= n_sp;
            r_cnt[idx]   <= n_cnt;
            r_mark[idx]  <= n_mark;
        end
    end

    a_newly_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.newly_stuck) |-> r_out.stuck_flag)
        else $error("newly_stuck without stuck_flag");

    a_newly_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.newly_stuck) |-> (r_out.stuck_count_now != '0))
        else $error("newly_stuck with zero count");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted word not held in input register");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline is stalled");

endmodule
